>>> src/obstacle_clearance_speed_map_defines.svh
// Assertion macros for the obstacle clearance speed map.
// Used by the controller; needs a clock and a reset in scope.
`ifndef OBSTACLE_CLEARANCE_SPEED_MAP_DEFINES_SVH
`define OBSTACLE_CLEARANCE_SPEED_MAP_DEFINES_SVH
// antecedent implies consequent in the next cycle
`define OCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
// antecedent implies consequent in the same cycle
`define OCSM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`endif

>>> src/ocsm_pkg.sv
// Shared types and constants of the obstacle clearance speed map.
// No dependencies.
package ocsm_pkg;
   localparam int Q16_ONE = 65536;
   localparam int SPEED_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT = 2'd2;

   typedef struct packed {
      logic mode;
      logic obstacle;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic frame_last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH,
      S_ROOT_A,
      S_ROOT_B
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan;
      logic root_a;
      logic root_b;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic scan_last;
      logic root_done;
   } stat_type;
endpackage

>>> src/ocsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ocsm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> src/ocsm_ctrl.sv
// Controller state machine of the obstacle clearance speed map.
// Depends on ocsm_pkg and obstacle_clearance_speed_map_defines.svh.
`include "obstacle_clearance_speed_map_defines.svh"
module ocsm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  ocsm_pkg::stat_type stat,
   output ocsm_pkg::cmd_type  cmd
);
   ocsm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // hold state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocsm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ocsm_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.emit) begin
                  state_in = ocsm_pkg::S_SCAN;
               end
            end
         end
         ocsm_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = ocsm_pkg::S_FLUSH;
            end
         end
         ocsm_pkg::S_FLUSH: begin
            state_in = ocsm_pkg::S_ROOT_A;
         end
         ocsm_pkg::S_ROOT_A: begin
            if (stat.root_done) begin
               // load the output register once it is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  cmd.finish = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = ocsm_pkg::S_IDLE;
               end
            end else begin
               cmd.root_a = 1'b1;
               state_in = ocsm_pkg::S_ROOT_B;
            end
         end
         ocsm_pkg::S_ROOT_B: begin
            cmd.root_b = 1'b1;
            state_in = ocsm_pkg::S_ROOT_A;
         end
         default: begin
            state_in = ocsm_pkg::S_IDLE;
         end
      endcase
   end

   `OCSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped")
   `OCSM_ASSERT_NEXT(a_scan, cmd.accept && stat.emit, state_ff == ocsm_pkg::S_SCAN, "no scan")
   `OCSM_ASSERT_NEXT(a_root_loop, cmd.root_b, state_ff == ocsm_pkg::S_ROOT_A, "root step lost")
   `OCSM_ASSERT_NOW(a_take_idle, cmd.accept, !req_stall && state_ff == ocsm_pkg::S_IDLE, "busy")
   `OCSM_ASSERT_NOW(a_finish_free, cmd.finish, !rsp_valid || !rsp_stall, "result overwritten")
endmodule

>>> src/ocsm_dp.sv
// Datapath: configuration, counters, row store, window scan and root search.
// Depends on ocsm_pkg and ocsm_ram.
module ocsm_dp #(
   parameter int MAX_RADIUS = 15,
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ocsm_pkg::req_type                   req_data,
   output ocsm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   input  logic [ocsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ocsm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  ocsm_pkg::cmd_type                   cmd,
   output ocsm_pkg::stat_type                  stat
);
   localparam int NSLOT = 2 * MAX_RADIUS + 1;
   localparam int SW = $clog2(NSLOT);
   localparam int DEPTH = NSLOT * MAX_WIDTH;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int HRW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RADW = $clog2(MAX_RADIUS + 1);
   localparam int LW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int DW = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
   localparam int OW = RADW + 1;
   localparam int PW = 36 + 2 * RADW;
   localparam int CMPW = (PW > DW + 34) ? PW : DW + 34;
   localparam int SPW = ocsm_pkg::SPEED_W;

   logic [3:0]  radius_ff;
   logic [10:0] map_width_ff, map_height_ff;
   logic [RADW-1:0] rad;
   logic [WW-1:0] w;
   logic [HW-1:0] h;
   logic [LW-1:0] total_m1, thresh;
   logic [2*RADW-1:0] rsq;
   logic restart;

   logic [CW-1:0] in_col_ff, out_col_ff;
   logic [SW-1:0] in_slot_ff, out_slot_ff, scan_slot_ff;
   logic [LW-1:0] in_lin_ff, out_lin_ff;
   logic [HRW-1:0] out_row_ff;
   logic complete_ff;

   logic signed [OW-1:0] dr_ff, dc_ff;
   logic signed [HRW+1:0] rr;
   logic signed [CW+1:0] cc;
   logic inmap;
   logic [DW-1:0] d, pd_ff, best_ff;
   logic pv_ff;
   logic [AW-1:0] raddr, waddr;
   logic rdata, pixel_wr;
   logic [SW:0] slot_start;
   logic [SPW-1:0] lo_ff, hi_ff, mid_ff;
   logic [SPW:0] mid_sum;
   logic [SPW:0] t_val;
   logic [35:0] sq_ff;
   logic [CMPW-1:0] prod, lim;
   logic ge, last;

   // saturate the registers to the supported range
   always_comb begin
      if (radius_ff == 4'd0) begin
         rad = RADW'(1);
      end else if (32'(radius_ff) > MAX_RADIUS) begin
         rad = RADW'(MAX_RADIUS);
      end else begin
         rad = RADW'(radius_ff);
      end
      if (map_width_ff == 11'd0) begin
         w = WW'(1);
      end else if (32'(map_width_ff) > MAX_WIDTH) begin
         w = WW'(MAX_WIDTH);
      end else begin
         w = WW'(map_width_ff);
      end
      if (map_height_ff == 11'd0) begin
         h = HW'(1);
      end else if (32'(map_height_ff) > MAX_HEIGHT) begin
         h = HW'(MAX_HEIGHT);
      end else begin
         h = HW'(map_height_ff);
      end
      total_m1 = LW'(LW'(w) * LW'(h) - LW'(1));
      thresh = LW'(LW'(rad) * LW'(w) + LW'(rad));
      rsq = (2*RADW)'(rad) * (2*RADW)'(rad);
   end

   assign restart = csr_valid && (csr_index == ocsm_pkg::REG_RADIUS
      || csr_index == ocsm_pkg::REG_MAP_WIDTH || csr_index == ocsm_pkg::REG_MAP_HEIGHT);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd5;
         map_width_ff <= 11'd1024;
         map_height_ff <= 11'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            ocsm_pkg::REG_RADIUS: radius_ff <= csr_data[3:0];
            ocsm_pkg::REG_MAP_WIDTH: map_width_ff <= csr_data;
            ocsm_pkg::REG_MAP_HEIGHT: map_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign pixel_wr = cmd.accept && !req_data.mode && !complete_ff;
   assign stat.emit = (pixel_wr && in_lin_ff >= thresh) || (cmd.accept && complete_ff);
   assign last = out_lin_ff >= total_m1;

   // input and output cell counters
   always_ff @(posedge clock) begin
      if (reset || restart || (cmd.finish && last)) begin
         in_col_ff <= '0;
         in_slot_ff <= '0;
         in_lin_ff <= '0;
         complete_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_slot_ff <= '0;
         out_lin_ff <= '0;
      end else begin
         if (pixel_wr) begin
            if (in_lin_ff >= total_m1) begin
               complete_ff <= 1'b1;
               in_col_ff <= '0;
               in_slot_ff <= '0;
               in_lin_ff <= '0;
            end else begin
               in_lin_ff <= in_lin_ff + LW'(1);
               if (WW'(in_col_ff) + WW'(1) >= w) begin
                  in_col_ff <= '0;
                  in_slot_ff <= (32'(in_slot_ff) == NSLOT - 1) ? '0 : in_slot_ff + SW'(1);
               end else begin
                  in_col_ff <= in_col_ff + CW'(1);
               end
            end
         end
         if (cmd.finish) begin
            out_lin_ff <= out_lin_ff + LW'(1);
            if (WW'(out_col_ff) + WW'(1) >= w) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + HRW'(1);
               out_slot_ff <= (32'(out_slot_ff) == NSLOT - 1) ? '0 : out_slot_ff + SW'(1);
            end else begin
               out_col_ff <= out_col_ff + CW'(1);
            end
         end
      end
   end

   // window cell under scan
   always_comb begin
      rr = $signed({2'b00, out_row_ff}) + (HRW+2)'(dr_ff);
      cc = $signed({2'b00, out_col_ff}) + (CW+2)'(dc_ff);
      inmap = (rr >= 0) && (rr < $signed({1'b0, (HRW+1)'(h)}))
         && (cc >= 0) && (cc < $signed({1'b0, (CW+1)'(w)}));
      d = DW'(dr_ff * dr_ff) + DW'(dc_ff * dc_ff);
      raddr = AW'(AW'(scan_slot_ff) * AW'(MAX_WIDTH) + AW'(cc[CW-1:0]));
      waddr = AW'(AW'(in_slot_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff));
      slot_start = ({1'b0, out_slot_ff} >= (SW+1)'(rad))
         ? {1'b0, out_slot_ff} - (SW+1)'(rad)
         : {1'b0, out_slot_ff} + (SW+1)'(NSLOT) - (SW+1)'(rad);
   end

   assign stat.scan_last = (dr_ff == $signed(OW'(rad))) && (dc_ff == $signed(OW'(rad)));

   ocsm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_rows (
      .clock (clock),
      .we    (pixel_wr),
      .waddr (waddr),
      .wdata (req_data.obstacle),
      .raddr (raddr),
      .rdata (rdata)
   );

   // walk the window, one read a cycle, and keep the nearest obstacle
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.scan && inmap;
      end
      pd_ff <= d;
      if (stat.emit) begin
         dr_ff <= -$signed(OW'(rad));
         dc_ff <= -$signed(OW'(rad));
         scan_slot_ff <= SW'(slot_start);
         best_ff <= '1;
         lo_ff <= '0;
         hi_ff <= SPW'(ocsm_pkg::Q16_ONE);
      end else begin
         if (cmd.scan) begin
            if (dc_ff == $signed(OW'(rad))) begin
               dc_ff <= -$signed(OW'(rad));
               dr_ff <= dr_ff + OW'(1);
               scan_slot_ff <= (32'(scan_slot_ff) == NSLOT - 1) ? '0 : scan_slot_ff + SW'(1);
            end else begin
               dc_ff <= dc_ff + OW'(1);
            end
         end
         if (pv_ff && rdata && pd_ff < best_ff) begin
            best_ff <= pd_ff;
         end
         if (cmd.root_b) begin
            if (prod <= lim) begin
               lo_ff <= mid_ff;
            end else begin
               hi_ff <= mid_ff - SPW'(1);
            end
         end
      end
   end

   // binary search for the scaled root: largest s with (2s-1)^2 r^2 <= m 2^34
   always_comb begin
      mid_sum = ({1'b0, lo_ff} + {1'b0, hi_ff} + (SPW+1)'(1)) >> 1;
      t_val = {mid_sum[SPW-1:0], 1'b0} - (SPW+1)'(1);
      prod = CMPW'(sq_ff) * CMPW'(rsq);
      lim = CMPW'(best_ff) << 34;
      ge = 32'(best_ff) >= 32'(rsq);
   end

   assign stat.root_done = ge || (lo_ff == hi_ff);

   always_ff @(posedge clock) begin
      if (cmd.root_a) begin
         mid_ff <= mid_sum[SPW-1:0];
         sq_ff <= 36'(t_val) * 36'(t_val);
      end
      if (cmd.finish) begin
         rsp_data.speed <= ge ? SPW'(ocsm_pkg::Q16_ONE) : lo_ff;
         rsp_data.frame_last <= last;
      end
   end
endmodule

>>> src/obstacle_clearance_speed_map.sv
// Top level of the obstacle clearance speed map.
// Depends on ocsm_pkg, ocsm_ctrl, ocsm_dp (and ocsm_ram below it).
//
// Usage: the map arrives on req_ in raster order, one cell per item
// (mode 0 = pixel with its obstacle bit, mode 1 = drain). Each result on
// rsp_ carries a Q1.16 speed and frame_last for the final cell. Results
// trail the input by R rows plus R cells; once the whole frame is in,
// each drain item yields the next result. A pixel sent on a finished
// frame acts as a drain. Registers radius, map_width, map_height are
// to be written on csr_ (always ready) only while the block is idle, which
// the block itself does not enforce; a write restarts the frame.
// An item that yields no result is only accepted. One that yields a result
// is accepted, reads the row store once per cell of the (2R+1)^2 window,
// settles the last read, runs the root search (a step is S_ROOT_A then
// S_ROOT_B; up to 17 steps, none when no obstacle is nearer than R) and loads
// the output register; no new item is taken until then. Its result is valid
// on rsp_ the next cycle and holds while rsp_stall is high; items are still
// taken meanwhile, but the next result waits for a free output register.
// Reset restores the register defaults and clears the frame counters.
module obstacle_clearance_speed_map #(
   parameter int MAX_RADIUS = 15,
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ocsm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ocsm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ocsm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ocsm_pkg::CSR_DATA_W-1:0]   csr_data
);
   ocsm_pkg::cmd_type cmd;
   ocsm_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ocsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ocsm_dp #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );
endmodule
